// ===== hdl/erx_pkg.sv =====
// Shared types and constants for the extent run translator.
// Used by erx_cell, extent_run_translator_core and erx_checker; no dependencies.

package erx_pkg;

  // Item opcodes carried on in_op.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // Width of the base count register and of a load's slot index.
  localparam int CFG_W = 5;
  localparam int IDX_W = 4;

  // Result count carried with the walk token, and the cap on results per run.
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] OUT_CAP = 5'd16;

  // Per-cell event report: a produced result, the end of the walk, an error result.
  typedef struct packed {
    logic res_v;
    logic stop;
    logic err;
  } erx_ev_t;

endpackage

// ===== hdl/erx_cell.sv =====
// One cell of the translation chain: holds one base extent and steps the walk token.
// Depends on erx_pkg.

module erx_cell #(
  parameter int OFFSET_BITS = 48,
  parameter int IDX         = 0,
  parameter bit LAST_CELL   = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [erx_pkg::CFG_W-1:0]     base_count,
  input  logic                          ld_en,
  input  logic [erx_pkg::IDX_W-1:0]     ld_idx,
  input  logic [OFFSET_BITS-1:0]        ld_start,
  input  logic [OFFSET_BITS-2:0]        ld_length,
  input  logic                          tin_v,
  input  logic [OFFSET_BITS-2:0]        tin_addr,
  input  logic [OFFSET_BITS-2:0]        tin_left,
  input  logic [erx_pkg::CNT_W-1:0]     tin_cnt,
  output logic                          tout_v,
  output logic [OFFSET_BITS-2:0]        tout_addr,
  output logic [OFFSET_BITS-2:0]        tout_left,
  output logic [erx_pkg::CNT_W-1:0]     tout_cnt,
  output erx_pkg::erx_ev_t              ev,
  output logic [OFFSET_BITS-1:0]        res_start,
  output logic [OFFSET_BITS-2:0]        res_length
);
  import erx_pkg::*;

  localparam int SW = OFFSET_BITS;
  localparam int LW = OFFSET_BITS - 1;

  logic [SW-1:0]    bs_r;
  logic [LW-1:0]    bl_r;
  logic             tok_v_r;
  logic [LW-1:0]    tok_addr_r;
  logic [LW-1:0]    tok_left_r;
  logic [CNT_W-1:0] tok_cnt_r;

  logic             run_ok;
  logic [LW-1:0]    avail;
  logic [LW-1:0]    take;
  logic [LW-1:0]    left_after;
  logic [SW-1:0]    phys_sum;
  logic [SW-1:0]    phys;
  logic [CNT_W-1:0] cnt_inc;
  logic             stop_run;

  // The extent held by this cell is written by a load aimed at its slot.
  always_ff @(posedge clk) begin
    if (ld_en && (32'(ld_idx) == 32'(IDX))) begin
      bs_r <= ld_start;
      bl_r <= ld_length;
    end
  end

  // Token register: takes the neighbor's token whenever the chain advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else if (adv) begin
      tok_v_r <= tin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_addr_r <= tin_addr;
      tok_left_r <= tin_left;
      tok_cnt_r  <= tin_cnt;
    end
  end

  // Step arithmetic. The base start is known non-negative where the sum is used,
  // and the offset is below the extent length, so the sum cannot wrap.
  assign run_ok     = (32'(base_count) > 32'(IDX)) && (tok_left_r != '0) &&
                      (tok_cnt_r < OUT_CAP);
  assign avail      = bl_r - tok_addr_r;
  assign take       = (avail > tok_left_r) ? tok_left_r : avail;
  assign left_after = (avail >= tok_left_r) ? '0 : (tok_left_r - avail);
  assign phys_sum   = bs_r + {1'b0, tok_addr_r};
  assign phys       = phys_sum[SW-1] ? {1'b0, {LW{1'b1}}} : phys_sum;
  assign cnt_inc    = tok_cnt_r + CNT_W'(1);
  assign stop_run   = LAST_CELL || (left_after == '0) || (cnt_inc == OUT_CAP);

  // Decide what this cell does with the token: end the walk, skip the extent,
  // report a base hole, or emit a clipped physical run.
  always_comb begin
    ev         = '0;
    tout_v     = 1'b0;
    tout_addr  = tok_addr_r;
    tout_left  = tok_left_r;
    tout_cnt   = tok_cnt_r;
    res_start  = '0;
    res_length = '0;
    if (tok_v_r) begin
      if (!run_ok) begin
        ev.stop = 1'b1;
      end else if (tok_addr_r >= bl_r) begin
        tout_addr = tok_addr_r - bl_r;
        ev.stop   = LAST_CELL;
        tout_v    = !LAST_CELL;
      end else if (bs_r[SW-1]) begin
        ev.res_v = 1'b1;
        ev.err   = 1'b1;
        ev.stop  = 1'b1;
      end else begin
        ev.res_v   = 1'b1;
        res_start  = phys;
        res_length = take;
        tout_addr  = '0;
        tout_left  = left_after;
        tout_cnt   = cnt_inc;
        ev.stop    = stop_run;
        tout_v     = !stop_run;
      end
    end
  end

endmodule

// ===== hdl/extent_run_translator_core.sv =====
// Top level of the extent run translator: cell chain, result holding and output register.
// Depends on erx_pkg and erx_cell.

// A load transaction writes one table slot. A translate transaction with a negative
// start gives one hole result, via the held result register and the output register.
// Any other translate sends a token down a chain of MAX_EXTENTS cells, one cell per
// cycle, and keeps the block busy until the walk ends (at the last cell at the latest)
// and any final result has moved to the output register; the chain pauses while a
// result waits for a full output register. Each result is held until the next one
// arrives, so the final one carries last_out and leaves only after the walk ends.

module extent_run_translator_core #(
  parameter int MAX_EXTENTS = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [erx_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [erx_pkg::IDX_W-1:0]     in_entry_index,
  input  logic signed [OFFSET_BITS-1:0] in_base_start,
  input  logic [OFFSET_BITS-2:0]        in_base_length,
  input  logic signed [OFFSET_BITS-1:0] in_run_start,
  input  logic [OFFSET_BITS-2:0]        in_run_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OFFSET_BITS-1:0] out_start,
  output logic [OFFSET_BITS-2:0]        out_length,
  output logic                          out_is_error,
  output logic                          out_last_out
);
  import erx_pkg::*;

  localparam int SW = OFFSET_BITS;
  localparam int LW = OFFSET_BITS - 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] base_count_r;

  logic             pend_v_r, pend_v_nxt;
  logic [SW-1:0]    pend_start_r, pend_start_nxt;
  logic [LW-1:0]    pend_len_r, pend_len_nxt;
  logic             pend_err_r, pend_err_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [SW-1:0]    out_start_r, out_start_nxt;
  logic [LW-1:0]    out_len_r, out_len_nxt;
  logic             out_err_r, out_err_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc;
  logic             ld_en;
  logic             xl_en;
  logic             run_hole;
  logic             ofree;
  logic             adv;

  // Token chain: index 0 is the injected token, index j+1 leaves cell j.
  logic             ch_v    [MAX_EXTENTS+1];
  logic [LW-1:0]    ch_addr [MAX_EXTENTS+1];
  logic [LW-1:0]    ch_left [MAX_EXTENTS+1];
  logic [CNT_W-1:0] ch_cnt  [MAX_EXTENTS+1];

  erx_ev_t          ev_a    [MAX_EXTENTS];
  logic [SW-1:0]    rs_a    [MAX_EXTENTS];
  logic [LW-1:0]    rl_a    [MAX_EXTENTS];
  erx_ev_t          ev_any;
  logic [SW-1:0]    rs_any;
  logic [LW-1:0]    rl_any;

  // Input handshake: a transaction is taken only while no translation is in flight.
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ld_en    = in_acc && (in_op == OP_LOAD);
  assign xl_en    = in_acc && (in_op == OP_XLATE);
  assign run_hole = in_run_start[SW-1];

  // Base count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_count_r <= '0;
    end else if (cfg_we) begin
      base_count_r <= cfg_wdata;
    end
  end

  // Inject a fresh token for a translate of a mapped run.
  assign ch_v[0]    = xl_en && !run_hole;
  assign ch_addr[0] = in_run_start[LW-1:0];
  assign ch_left[0] = in_run_length;
  assign ch_cnt[0]  = '0;

  // The row of cells.
  for (genvar j = 0; j < MAX_EXTENTS; j++) begin : g_cell
    erx_cell #(
      .OFFSET_BITS (OFFSET_BITS),
      .IDX         (j),
      .LAST_CELL   (j == MAX_EXTENTS - 1)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .base_count (base_count_r),
      .ld_en      (ld_en),
      .ld_idx     (in_entry_index),
      .ld_start   (in_base_start),
      .ld_length  (in_base_length),
      .tin_v      (ch_v[j]),
      .tin_addr   (ch_addr[j]),
      .tin_left   (ch_left[j]),
      .tin_cnt    (ch_cnt[j]),
      .tout_v     (ch_v[j+1]),
      .tout_addr  (ch_addr[j+1]),
      .tout_left  (ch_left[j+1]),
      .tout_cnt   (ch_cnt[j+1]),
      .ev         (ev_a[j]),
      .res_start  (rs_a[j]),
      .res_length (rl_a[j])
    );
  end

  // At most one cell holds the token, and idle cells report zeros, so an OR merges them.
  always_comb begin
    ev_any = '0;
    rs_any = '0;
    rl_any = '0;
    for (int k = 0; k < MAX_EXTENTS; k++) begin
      ev_any = ev_any | ev_a[k];
      rs_any = rs_any | rs_a[k];
      rl_any = rl_any | rl_a[k];
    end
  end

  // The chain pauses only when a new result must push the held one into a full output.
  assign ofree = !out_valid_r || out_ready;
  assign adv   = !(ev_any.res_v && pend_v_r && !ofree);

  // Control of the held result and the output register.
  always_comb begin
    state_nxt      = state_r;
    pend_v_nxt     = pend_v_r;
    pend_start_nxt = pend_start_r;
    pend_len_nxt   = pend_len_r;
    pend_err_nxt   = pend_err_r;
    out_valid_nxt  = out_valid_r;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (xl_en) begin
          if (run_hole) begin
            pend_v_nxt     = 1'b1;
            pend_start_nxt = {SW{1'b1}};
            pend_len_nxt   = in_run_length;
            pend_err_nxt   = 1'b0;
            state_nxt      = ST_FLUSH;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (adv) begin
          if (ev_any.res_v) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_start_nxt = pend_start_r;
              out_len_nxt   = pend_len_r;
              out_err_nxt   = pend_err_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt     = 1'b1;
            pend_start_nxt = rs_any;
            pend_len_nxt   = rl_any;
            pend_err_nxt   = ev_any.err;
          end
          if (ev_any.stop) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (ofree) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = pend_start_r;
          out_len_nxt   = pend_len_r;
          out_err_nxt   = pend_err_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    pend_start_r <= pend_start_nxt;
    pend_len_r   <= pend_len_nxt;
    pend_err_r   <= pend_err_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    out_err_r    <= out_err_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_start    = out_start_r;
  assign out_length   = out_len_r;
  assign out_is_error = out_err_r;
  assign out_last_out = out_last_r;

endmodule

// ===== hdl/erx_checker.sv =====
// Port-level checks for extent_run_translator_core, with the bind that attaches them.
// Depends on erx_pkg and on the top level's port list.

module erx_checker #(
  parameter int OFFSET_BITS = 48
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [OFFSET_BITS-1:0] out_start,
  input logic [OFFSET_BITS-2:0]        out_length,
  input logic                          out_is_error,
  input logic                          out_last_out
);
  import erx_pkg::*;

  // No result transaction is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start) &&
    $stable(out_length) && $stable(out_is_error) && $stable(out_last_out))
    else $error("stalled result changed");

  // An error result is empty and ends its translation.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_error |-> out_last_out && (out_start == '0) && (out_length == '0))
    else $error("malformed error result");

  // A hole run is the only result of its translation and is never an error.
  a_hole_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_start == {OFFSET_BITS{1'b1}}) |-> out_last_out && !out_is_error)
    else $error("malformed hole result");

  // A load transaction leaves the block ready for the next transaction.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_LOAD) |=> in_ready)
    else $error("block busy after a load");

endmodule

bind extent_run_translator_core erx_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_erx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_start    (out_start),
  .out_length   (out_length),
  .out_is_error (out_is_error),
  .out_last_out (out_last_out)
);
